/* design/eabs_pkg.sv */
package eabs_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int DATA_W    = 8;
    localparam int RES_W     = 16;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int NUM_W     = SUM_W + 9;
    localparam int X_W       = NUM_W - 1;
    localparam int RCP_W     = 23;
    localparam int RCP_S     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

    // floor(2^24 / 3) and floor(2^24 / 9)
    localparam logic [RCP_W-1:0] RCP_THREE = 23'd5592405;
    localparam logic [RCP_W-1:0] RCP_NINE  = 23'd1864135;

    typedef enum logic [1:0] {
        M_ONE,
        M_THREE,
        M_NINE
    } t_mcode;

    typedef struct packed {
        logic [1:0] shift;
        t_mcode     m;
    } t_div_plan;

    typedef struct packed {
        logic row0;
        logic row1;
        logic row2;
        logic left;
        logic right;
        logic last;
    } t_tap_mask;

    typedef struct packed {
        logic      rd;
        logic      upd;
        logic      sum;
        logic      mul;
        logic      fix;
        logic      load;
        t_tap_mask mask;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    // Divisor 2n is split into a power of two and an odd factor of 1, 3 or 9.
    function automatic t_div_plan div_plan(input logic [CNT_W-1:0] n);
        t_div_plan p;
        case (n)
            4'd1: begin p.shift = 2'd1; p.m = M_ONE;   end
            4'd2: begin p.shift = 2'd2; p.m = M_ONE;   end
            4'd3: begin p.shift = 2'd1; p.m = M_THREE; end
            4'd4: begin p.shift = 2'd3; p.m = M_ONE;   end
            4'd6: begin p.shift = 2'd2; p.m = M_THREE; end
            4'd9: begin p.shift = 2'd1; p.m = M_NINE;  end
            default: begin p.shift = 2'd1; p.m = M_ONE; end
        endcase
        return p;
    endfunction

endpackage

/* design/eabs_ctrl.sv */
module eabs_ctrl
    import eabs_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    localparam int COL_W  = $clog2(MAX_COLS),
    localparam int COLN_W = $clog2(MAX_COLS + 1),
    localparam int ROW_W  = $clog2(MAX_ROWS + 2)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_dp_cmd              o_cmd,
    output logic [COL_W-1:0]     o_addr,
    input  t_dp_stat             i_stat
);

    localparam int RST_ROWS = (MAX_ROWS < 256) ? MAX_ROWS : 256;
    localparam int RST_COLS = (MAX_COLS < 256) ? MAX_COLS : 256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_MUL,
        S_FIX,
        S_OUT
    } t_state;

    t_state             r_state, n_state;
    logic               r_in_stall;
    logic               r_has_res;
    t_tap_mask          r_mask;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_nr;
    logic [COLN_W-1:0]  r_nc;

    logic               accept;
    logic               col_zero, case_a, case_b, wrap;
    logic [ROW_W-1:0]   tr;
    logic [COLN_W-1:0]  tc, col_inc;
    t_tap_mask          n_mask;

    function automatic logic [ROW_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        if (v == '0) return ROW_W'(1);
        if (int'(v) > MAX_ROWS) return ROW_W'(MAX_ROWS);
        return ROW_W'(v);
    endfunction

    function automatic logic [COLN_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        if (v == '0) return COLN_W'(1);
        if (int'(v) > MAX_COLS) return COLN_W'(MAX_COLS);
        return COLN_W'(v);
    endfunction

    assign accept = i_in_valid && !r_in_stall;

    // Decide at accept which taps of the shifted window fall inside the grid.
    always_comb begin
        col_zero = (r_col == '0);
        case_a   = col_zero && (r_row >= ROW_W'(2));
        case_b   = !col_zero && (r_row != '0);
        wrap     = col_zero && (r_row > r_nr);
        tr       = case_a ? r_row - ROW_W'(2) : r_row - ROW_W'(1);
        tc       = case_a ? r_nc - COLN_W'(1) : COLN_W'(r_col) - COLN_W'(1);
        col_inc  = COLN_W'(r_col) + COLN_W'(1);
        n_mask.row0  = (tr != '0);
        n_mask.row1  = (tr < r_nr);
        n_mask.row2  = ((tr + ROW_W'(1)) < r_nr);
        n_mask.left  = (tc != '0);
        n_mask.right = ((tc + COLN_W'(1)) < r_nc);
        n_mask.last  = case_a && (r_row > r_nr);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ:  n_state = r_has_res ? S_SUM : S_IDLE;
            S_SUM:   n_state = S_MUL;
            S_MUL:   n_state = S_FIX;
            S_FIX:   n_state = S_OUT;
            S_OUT:   if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b1;
            r_has_res  <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_nr       <= ROW_W'(RST_ROWS);
            r_nc       <= COLN_W'(RST_COLS);
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
            if (accept) begin
                r_has_res <= case_a || case_b;
                r_mask    <= n_mask;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NUM_ROWS: begin
                        r_nr  <= clamp_rows(i_cfg_data);
                        r_row <= '0;
                        r_col <= '0;
                    end
                    REG_NUM_COLS: begin
                        r_nc  <= clamp_cols(i_cfg_data);
                        r_row <= '0;
                        r_col <= '0;
                    end
                    default: ;
                endcase
            end else if (accept) begin
                if (wrap) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (col_inc >= r_nc) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= COL_W'(col_inc);
                end
            end
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_addr      = r_col;
    assign o_cmd.rd    = accept;
    assign o_cmd.upd   = (r_state == S_READ);
    assign o_cmd.sum   = (r_state == S_SUM);
    assign o_cmd.mul   = (r_state == S_MUL);
    assign o_cmd.fix   = (r_state == S_FIX);
    assign o_cmd.load  = (r_state == S_OUT) && i_stat.out_free;
    assign o_cmd.mask  = r_mask;

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_state == S_IDLE))
        else $error("beat accepted outside idle");

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_READ))
        else $error("accepted beat did not start a line buffer read");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        COLN_W'(r_col) < r_nc)
        else $error("column position beyond row length");

endmodule

/* design/eabs_datapath.sv */
module eabs_datapath
    import eabs_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    localparam int COL_W = $clog2(MAX_COLS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [COL_W-1:0]  i_addr,
    input  logic [DATA_W-1:0] i_height,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [RES_W-1:0]  o_smoothed,
    output logic              o_last
);

    localparam int P_W = X_W + RCP_W;
    localparam int M_W = X_W + 4;

    logic [DATA_W-1:0] upper_mem  [MAX_COLS];
    logic [DATA_W-1:0] middle_mem [MAX_COLS];

    logic [DATA_W-1:0] r_win [3][3];
    logic [DATA_W-1:0] r_up_rd, r_mid_rd, r_v;
    logic [COL_W-1:0]  r_addr;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_n;
    logic [X_W-1:0]    r_x, r_q0;
    t_mcode            r_m;
    logic [RES_W-1:0]  r_res;
    logic              r_out_valid;
    logic [RES_W-1:0]  r_smoothed;
    logic              r_last;

    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  cnt;
    t_div_plan         plan;
    logic [NUM_W-1:0]  num;
    logic [X_W-1:0]    x, q0;
    logic [RCP_W-1:0]  rcp;
    logic [P_W-1:0]    prod;
    logic [M_W-1:0]    mq, rem;
    logic [3:0]        m_val;
    logic [X_W-1:0]    q;

    // Line buffers: read at accept, write back at the same column next cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_up_rd  <= upper_mem[i_addr];
            r_mid_rd <= middle_mem[i_addr];
        end
        if (i_cmd.upd) begin
            upper_mem[r_addr]  <= r_mid_rd;
            middle_mem[r_addr] <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_v    <= i_height;
            r_addr <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_cmd.upd) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_up_rd;
            r_win[1][2] <= r_mid_rd;
            r_win[2][2] <= r_v;
        end
    end

    // Masked tap sum; column 1 of the window is always the center.
    always_comb begin
        logic [2:0] rv;
        logic [2:0] cv;
        rv  = {i_cmd.mask.row2, i_cmd.mask.row1, i_cmd.mask.row0};
        cv  = {i_cmd.mask.right, 1'b1, i_cmd.mask.left};
        sum = '0;
        cnt = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (rv[r] && cv[c]) begin
                    sum = sum + SUM_W'(r_win[r][c]);
                    cnt = cnt + CNT_W'(1);
                end
            end
        end
    end

    // (512*sum + n) / 2n: shift by the power of two, then reciprocal multiply.
    always_comb begin
        plan = div_plan(r_n);
        num  = {r_sum, 9'(r_n)};
        x    = X_W'(num >> plan.shift);
        rcp  = (plan.m == M_THREE) ? RCP_THREE : RCP_NINE;
        prod = P_W'(x) * P_W'(rcp);
        q0   = (plan.m == M_ONE) ? x : X_W'(prod >> RCP_S);
    end

    // Reciprocal is rounded down, so the quotient is short by at most one.
    always_comb begin
        case (r_m)
            M_THREE: begin
                mq    = M_W'(r_q0) + (M_W'(r_q0) << 1);
                m_val = 4'd3;
            end
            M_NINE: begin
                mq    = M_W'(r_q0) + (M_W'(r_q0) << 3);
                m_val = 4'd9;
            end
            default: begin
                mq    = M_W'(r_q0);
                m_val = 4'd1;
            end
        endcase
        rem = M_W'(r_x) - mq;
        q   = (rem >= M_W'(m_val)) ? r_q0 + X_W'(1) : r_q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum <= sum;
            r_n   <= cnt;
        end
        if (i_cmd.mul) begin
            r_x  <= x;
            r_q0 <= q0;
            r_m  <= plan.m;
        end
        if (i_cmd.fix) begin
            r_res <= RES_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
            r_smoothed  <= r_res;
            r_last      <= i_cmd.mask.last;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_smoothed      = r_smoothed;
    assign o_last          = r_last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> o_stat.out_free)
        else $error("result loaded over a beat not yet taken");

    a_fix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fix |-> (rem < (M_W'(m_val) << 1)))
        else $error("reciprocal quotient off by more than one");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.load))
        else $error("output valid rose without a load");

endmodule

/* design/edge_aware_box_smooth_3x3_unit.sv */
// 3x3 neighborhood mean over a raster stream of 8-bit height samples.
// Input channel: i_in_valid / o_in_stall with i_height. Output channel:
// o_out_valid / i_out_stall with o_smoothed (unsigned 8.8, rounded to
// nearest, ties up) and o_last, set on the frame's final sample.
// Configuration: i_cfg_we writes i_cfg_data to num_rows (index 0) or
// num_cols (index 1); zero reads as one, values above the maximum clamp,
// and any write restarts the frame. Write only while the block is idle.
// The result for sample k leaves with item k+num_cols+1; after the last
// sample send num_cols+1 padding beats, then the next frame starts.
// An item that produces no result passes only through line buffer read
// and window shift and write-back; one that produces a result goes on
// through masked sum, reciprocal multiply, quotient correction and output
// load, which waits for a free output slot. With single-port line buffer
// reads and a shared divide path, each item finishes before the next.
// The output register holds a finished beat while i_out_stall is high; the
// next item is accepted meanwhile and waits in its load step.
// Reset clears the window, positions and output valid and restores both
// sizes to min(256, max); line buffers stay undefined, always masked.
module edge_aware_box_smooth_3x3_unit
    import eabs_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [DATA_W-1:0]    i_height,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [RES_W-1:0]     o_smoothed,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W = $clog2(MAX_COLS);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [COL_W-1:0] addr;

    eabs_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (cmd),
        .o_addr     (addr),
        .i_stat     (stat)
    );

    eabs_datapath #(
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_addr      (addr),
        .i_height    (i_height),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_smoothed  (o_smoothed),
        .o_last      (o_last)
    );

endmodule
